[src/angle_tour_two_opt_engine_macros.svh]
// Assertion macros for the angle tour 2-opt engine.
// Used by the top level only; no dependencies.
`ifndef ANGLE_TOUR_TWO_OPT_ENGINE_MACROS_SVH
`define ANGLE_TOUR_TWO_OPT_ENGINE_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define ATE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that a condition implies a consequence in the next cycle
`define ATE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/ate_pkg.sv]
// Shared types, constants and functions of the angle tour 2-opt engine.
// No dependencies.
package ate_pkg;

  localparam int MaxCities   = 256;
  localparam int IdxW        = 8;
  localparam int CntW        = 9;
  localparam int CoordW      = 16;
  localparam int DeltaW      = 21;
  localparam int EnergyW     = 26;
  localparam int AngW        = 18;
  localparam int ProdW       = 34;
  localparam int CordW       = 46;
  localparam int ZW          = 33;
  localparam int CordicSteps = 30;

  localparam logic [1:0] OpLoad      = 2'd0;
  localparam logic [1:0] OpPropose   = 2'd1;
  localparam logic [1:0] OpCommit    = 2'd2;
  localparam logic [1:0] OpRecompute = 2'd3;

  localparam logic [ZW-1:0] PiQ30     = 33'd3373259426;
  localparam logic [ZW-1:0] HalfPiQ30 = 33'd1686629713;
  localparam logic [EnergyW-1:0] EnergyMax = 26'h3FFFFFF;

  typedef struct packed {
    logic [IdxW-1:0] c;
    logic [IdxW-1:0] p;
    logic [IdxW-1:0] q;
  } triple_t;

  typedef struct packed {
    logic            start;
    triple_t         cities;
  } dev_req_t;

  typedef struct packed {
    logic            done;
    logic [AngW-1:0] dev;
  } dev_rsp_t;

  function automatic logic [ZW-1:0] step_angle(input logic [4:0] i);
    logic [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 33'd843314857;
        5'd1: r = 33'd497837829;
        5'd2: r = 33'd263043837;
        5'd3: r = 33'd133525159;
        5'd4: r = 33'd67021687;
        5'd5: r = 33'd33543516;
        5'd6: r = 33'd16775851;
        5'd7: r = 33'd8388437;
        5'd8: r = 33'd4194283;
        5'd9: r = 33'd2097149;
        default: r = ZW'(64'd1 << (5'd30 - i));
      endcase
      return r;
    end
  endfunction

endpackage

[src/ate_cordic.sv]
// Iterative vectoring CORDIC: atan2(|cross|, -dot) in [0, pi], rounded to Q.16.
// One normalize or rotation step per cycle. Depends on ate_pkg.
module ate_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ate_pkg::ProdW-1:0]      ux,
  input  logic [ate_pkg::ProdW-1:0]      uy,
  input  logic                           neg_u,
  input  logic                           zero,
  output logic                           done,
  output logic [ate_pkg::AngW-1:0]       angle
);

  typedef enum logic [1:0] {S_IDLE, S_NORM, S_ROT, S_FIN} state_t;

  state_t state_r;
  logic signed [ate_pkg::CordW-1:0] x_r, y_r;
  logic signed [ate_pkg::ZW:0]      z_r;
  logic [4:0]                       i_r;
  logic                             neg_r;
  logic                             done_r;
  logic [ate_pkg::AngW-1:0]         angle_r;

  logic signed [ate_pkg::CordW-1:0] dx, dy;
  logic [ate_pkg::CordW-1:0]        big;
  logic signed [ate_pkg::ZW:0]      zc, za;
  logic [ate_pkg::ZW:0]             zr;

  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign big = (x_r > y_r) ? x_r : y_r;

  always_comb begin
    zc = z_r;
    if (z_r < 0) zc = '0;
    if (z_r > $signed({1'b0, ate_pkg::HalfPiQ30})) zc = $signed({1'b0, ate_pkg::HalfPiQ30});
    za = neg_r ? ($signed({1'b0, ate_pkg::PiQ30}) - zc) : zc;
    zr = za + (ate_pkg::ZW+1)'(1 << 13);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            x_r   <= $signed({12'd0, ux});
            y_r   <= $signed({12'd0, uy});
            z_r   <= '0;
            i_r   <= '0;
            neg_r <= neg_u;
            if (zero) begin
              angle_r <= '0;
              done_r  <= 1'b1;
            end else begin
              state_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (big[40] || big[41] || big[42] || big[43] || big[44]) begin
            state_r <= S_ROT;
          end else begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end
        end
        S_ROT: begin
          if (y_r > 0) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + $signed({1'b0, ate_pkg::step_angle(i_r)});
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - $signed({1'b0, ate_pkg::step_angle(i_r)});
          end
          if (i_r == 5'(ate_pkg::CordicSteps - 1)) state_r <= S_FIN;
          i_r <= i_r + 5'd1;
        end
        S_FIN: begin
          angle_r <= zr[ate_pkg::AngW+13:14];
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

[src/ate_dev_unit.sv]
// Deviation unit: reads three cities from the coordinate memory port,
// forms dot and cross products and runs the CORDIC. Depends on ate_pkg, ate_cordic.
module ate_dev_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ate_pkg::dev_req_t                 req,
  output ate_pkg::dev_rsp_t                 rsp,
  output logic [ate_pkg::IdxW-1:0]          rd_addr,
  input  logic signed [ate_pkg::CoordW-1:0] rd_x,
  input  logic signed [ate_pkg::CoordW-1:0] rd_y
);

  typedef enum logic [2:0] {S_IDLE, S_RC, S_RP, S_RQ, S_MUL, S_CORD} state_t;

  state_t state_r;
  ate_pkg::triple_t tri_r;
  logic signed [ate_pkg::CoordW-1:0] cx_r, cy_r, px_r, py_r;
  logic signed [ate_pkg::CoordW:0]   v1x_r, v1y_r, v2x_r, v2y_r;
  logic signed [ate_pkg::ProdW-1:0]  p1_r, p2_r, p3_r, p4_r;
  logic                              zero_r;
  logic                              cstart_r;

  logic signed [ate_pkg::ProdW:0] u, cr;
  logic [ate_pkg::ProdW-1:0]      au, ac;
  logic                           cdone;
  logic [ate_pkg::AngW-1:0]       cangle;

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = req.cities.c;
      S_RC:    rd_addr = tri_r.p;
      S_RP:    rd_addr = tri_r.q;
      default: rd_addr = tri_r.q;
    endcase
  end

  assign u  = -((ate_pkg::ProdW+1)'(p1_r) + (ate_pkg::ProdW+1)'(p2_r));
  assign cr = (ate_pkg::ProdW+1)'(p3_r) - (ate_pkg::ProdW+1)'(p4_r);
  assign au = ate_pkg::ProdW'(u[ate_pkg::ProdW] ? -u : u);
  assign ac = ate_pkg::ProdW'(cr[ate_pkg::ProdW] ? -cr : cr);

  ate_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cstart_r),
    .ux    (au),
    .uy    (ac),
    .neg_u (u[ate_pkg::ProdW]),
    .zero  (zero_r),
    .done  (cdone),
    .angle (cangle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cstart_r <= 1'b0;
    end else begin
      cstart_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (req.start) begin
          tri_r   <= req.cities;
          state_r <= S_RC;
        end
        S_RC: begin
          cx_r <= rd_x;
          cy_r <= rd_y;
          state_r <= S_RP;
        end
        S_RP: begin
          px_r <= rd_x;
          py_r <= rd_y;
          state_r <= S_RQ;
        end
        S_RQ: begin
          v1x_r <= (ate_pkg::CoordW+1)'(px_r) - (ate_pkg::CoordW+1)'(cx_r);
          v1y_r <= (ate_pkg::CoordW+1)'(py_r) - (ate_pkg::CoordW+1)'(cy_r);
          v2x_r <= (ate_pkg::CoordW+1)'(rd_x) - (ate_pkg::CoordW+1)'(cx_r);
          v2y_r <= (ate_pkg::CoordW+1)'(rd_y) - (ate_pkg::CoordW+1)'(cy_r);
          state_r <= S_MUL;
        end
        S_MUL: begin
          p1_r <= v1x_r * v2x_r;
          p2_r <= v1y_r * v2y_r;
          p3_r <= v1x_r * v2y_r;
          p4_r <= v1y_r * v2x_r;
          zero_r <= ((v1x_r == '0) && (v1y_r == '0)) || ((v2x_r == '0) && (v2y_r == '0));
          cstart_r <= 1'b1;
          state_r <= S_CORD;
        end
        S_CORD: if (cdone) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == S_CORD) && cdone;
  assign rsp.dev  = cangle;

endmodule

[src/ate_city_ram.sv]
// Coordinate memory: one write port, one registered read port per axis pair.
// Depends on ate_pkg.
module ate_city_ram (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ate_pkg::IdxW-1:0]          wr_addr,
  input  logic signed [ate_pkg::CoordW-1:0] wr_x,
  input  logic signed [ate_pkg::CoordW-1:0] wr_y,
  input  logic [ate_pkg::IdxW-1:0]          rd_addr,
  output logic signed [ate_pkg::CoordW-1:0] rd_x,
  output logic signed [ate_pkg::CoordW-1:0] rd_y
);

  logic [2*ate_pkg::CoordW-1:0] mem [ate_pkg::MaxCities];
  logic [2*ate_pkg::CoordW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {wr_y, wr_x};
    rd_r <= mem[rd_addr];
  end

  assign rd_x = rd_r[ate_pkg::CoordW-1:0];
  assign rd_y = rd_r[2*ate_pkg::CoordW-1:ate_pkg::CoordW];

endmodule

[src/angle_tour_two_opt_engine.sv]
// Angle tour 2-opt engine: load, propose, commit and recompute over a closed tour.
// Work per item: a load writes the coordinate memory; one deviation is three reads, products,
// up to 40 normalize steps and 30 CORDIC steps; propose runs up to eight of them through
// one read port; commit swaps up to 128 pairs of cities; recompute runs one
// deviation per city. One item at a time; the next item is accepted only after the
// result has been taken.
// Depends on ate_pkg, ate_city_ram, ate_dev_unit and the macros header.
`include "angle_tour_two_opt_engine_macros.svh"
module angle_tour_two_opt_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[1:0], city_index[9:2], city_x[25:10], city_y[41:26],
  // first_pick[49:42], second_pick[57:50], zero fill
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // first_index[7:0], second_index[15:8], delta[36:16], energy[62:37], zero fill
  output logic [63:0] out_tdata
);

  typedef enum logic [2:0] {S_IDLE, S_DEV, S_SWR, S_SWW, S_FIN} state_t;

  state_t state_r;
  logic [ate_pkg::CntW-1:0]    count_r;
  logic [ate_pkg::EnergyW-1:0] energy_r;
  logic [ate_pkg::IdxW-1:0]    plo_r, phi_r;
  logic signed [ate_pkg::DeltaW-1:0] pch_r;
  logic [1:0]                  op_r;
  logic [ate_pkg::CntW-1:0]    n_r;
  logic [ate_pkg::CntW-1:0]    k_r;
  logic signed [27:0]          acc_r;
  logic [ate_pkg::IdxW-1:0]    slo_r, shi_r;
  logic signed [ate_pkg::CoordW-1:0] hx_r, hy_r;
  logic                        swp_r;
  logic                        dstart_r;
  logic                        ovalid_r;
  logic [63:0]                 odata_r;

  logic [1:0]  in_op;
  logic [7:0]  in_idx, in_a, in_b;
  logic signed [15:0] in_x, in_y;
  assign in_op  = in_tdata[1:0];
  assign in_idx = in_tdata[9:2];
  assign in_x   = in_tdata[25:10];
  assign in_y   = in_tdata[41:26];
  assign in_a   = in_tdata[49:42];
  assign in_b   = in_tdata[57:50];

  logic wr_en;
  logic [ate_pkg::IdxW-1:0] wr_addr, ram_raddr, dev_raddr;
  logic signed [ate_pkg::CoordW-1:0] wr_x, wr_y, rd_x, rd_y;
  ate_pkg::dev_req_t dreq;
  ate_pkg::dev_rsp_t drsp;

  logic in_fire;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  ate_city_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_x(wr_x), .wr_y(wr_y),
    .rd_addr(ram_raddr), .rd_x(rd_x), .rd_y(rd_y)
  );

  ate_dev_unit u_dev (
    .clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp),
    .rd_addr(dev_raddr), .rd_x(rd_x), .rd_y(rd_y)
  );

  // tour neighbor arithmetic on slot k of n
  function automatic logic [7:0] prv(input logic [8:0] i, input logic [8:0] n);
    logic [8:0] r;
    begin
      r = (i == 9'd0) ? n - 9'd1 : i - 9'd1;
      return r[7:0];
    end
  endfunction
  function automatic logic [7:0] nxt(input logic [8:0] i, input logic [8:0] n);
    logic [8:0] r;
    begin
      r = (i == n - 9'd1) ? 9'd0 : i + 9'd1;
      return r[7:0];
    end
  endfunction

  logic [8:0] lo9, hi9, pl9, nh9;
  assign lo9 = {1'b0, plo_r};
  assign hi9 = {1'b0, phi_r};
  assign pl9 = {1'b0, prv(lo9, n_r)};
  assign nh9 = {1'b0, nxt(hi9, n_r)};

  // triple for propose step k: first four are old terms, last four new
  ate_pkg::triple_t ptri;
  always_comb begin
    unique case (k_r[2:0])
      3'd0: ptri = '{c: pl9[7:0], p: prv(pl9, n_r), q: plo_r};
      3'd1: ptri = '{c: plo_r, p: pl9[7:0], q: nxt(lo9, n_r)};
      3'd2: ptri = '{c: phi_r, p: prv(hi9, n_r), q: nh9[7:0]};
      3'd3: ptri = '{c: nh9[7:0], p: phi_r, q: nxt(nh9, n_r)};
      3'd4: ptri = '{c: pl9[7:0], p: prv(pl9, n_r), q: phi_r};
      3'd5: ptri = '{c: phi_r, p: pl9[7:0], q: prv(hi9, n_r)};
      3'd6: ptri = '{c: plo_r, p: nxt(lo9, n_r), q: nh9[7:0]};
      default: ptri = '{c: nh9[7:0], p: plo_r, q: nxt(nh9, n_r)};
    endcase
  end

  ate_pkg::triple_t rtri;
  assign rtri = '{c: k_r[7:0], p: prv(k_r, n_r), q: nxt(k_r, n_r)};

  assign dreq.start  = dstart_r;
  assign dreq.cities = (op_r == ate_pkg::OpPropose) ? ptri : rtri;

  logic [8:0] n_in, b_inc;
  logic [7:0] lo_new, hi_new;
  assign n_in  = (count_r > 9'd256) ? 9'd256 : count_r;
  assign b_inc = {1'b0, in_b} + 9'd1;
  assign lo_new = (in_b >= in_a) ? in_a : in_b;
  assign hi_new = (in_b >= in_a) ? b_inc[7:0] : in_a;

  logic bad_pick, trivial;
  logic [9:0] hp2;
  logic [9:0] hp2m;
  assign bad_pick = (n_in < 9'd2) || ({1'b0, in_a} > n_in - 9'd1) ||
                    ({1'b0, in_b} > n_in - 9'd2);
  assign hp2  = {2'b0, hi_new} + 10'd2;
  assign hp2m = (hp2 >= {1'b0, n_in}) ? hp2 - {1'b0, n_in} : hp2;
  assign trivial = ((lo_new == 8'd0) && ({1'b0, hi_new} == n_in - 9'd1)) ||
                   (hp2m == {2'b0, lo_new});

  logic signed [27:0] e_sum;
  logic [ate_pkg::EnergyW-1:0] e_sat;
  assign e_sum = $signed({2'b0, energy_r}) + 28'(pch_r);
  assign e_sat = (e_sum < 0) ? '0 :
                 (e_sum > $signed({2'b0, ate_pkg::EnergyMax})) ? ate_pkg::EnergyMax :
                 e_sum[ate_pkg::EnergyW-1:0];

  logic [ate_pkg::EnergyW-1:0] r_sat;
  assign r_sat = (acc_r > $signed({2'b0, ate_pkg::EnergyMax})) ? ate_pkg::EnergyMax :
                 acc_r[ate_pkg::EnergyW-1:0];

  always_comb begin
    wr_en = 1'b0;
    wr_addr = in_idx;
    wr_x = in_x;
    wr_y = in_y;
    ram_raddr = dev_raddr;
    if (in_fire && in_op == ate_pkg::OpLoad) begin
      wr_en = 1'b1;
    end else if (state_r == S_SWR) begin
      ram_raddr = swp_r ? shi_r : slo_r;
      if (swp_r) begin
        wr_en = 1'b1;
        wr_addr = shi_r;
        wr_x = hx_r;
        wr_y = hy_r;
      end
    end else if (state_r == S_SWW && swp_r) begin
      wr_en = 1'b1;
      wr_addr = slo_r;
      wr_x = rd_x;
      wr_y = rd_y;
    end
  end

  // swap: read lo and hold it, then read old hi while writing held lo into hi,
  // then write old hi into lo
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      energy_r <= '0;
      plo_r    <= '0;
      phi_r    <= '0;
      pch_r    <= '0;
      ovalid_r <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      dstart_r <= 1'b0;
      if (cfg_valid) count_r <= cfg_data;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          op_r <= in_op;
          n_r  <= n_in;
          k_r  <= '0;
          acc_r <= '0;
          unique case (in_op)
            ate_pkg::OpLoad: state_r <= S_FIN;
            ate_pkg::OpPropose: begin
              if (bad_pick) begin
                plo_r <= '0; phi_r <= '0; pch_r <= '0;
                state_r <= S_FIN;
              end else begin
                plo_r <= lo_new; phi_r <= hi_new; pch_r <= '0;
                if (trivial) begin
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_DEV;
                  dstart_r <= 1'b1;
                end
              end
            end
            ate_pkg::OpCommit: begin
              energy_r <= e_sat;
              slo_r <= plo_r;
              shi_r <= phi_r;
              swp_r <= 1'b0;
              state_r <= (plo_r < phi_r) ? S_SWR : S_FIN;
            end
            default: begin
              if (n_in < 9'd2) begin
                energy_r <= '0;
                state_r <= S_FIN;
              end else begin
                state_r <= S_DEV;
                dstart_r <= 1'b1;
              end
            end
          endcase
        end
        S_DEV: begin
          if (drsp.done) begin
            if (op_r == ate_pkg::OpPropose) begin
              acc_r <= (k_r[2]) ? acc_r + 28'(drsp.dev) : acc_r - 28'(drsp.dev);
              if (k_r == 9'd7) begin
                state_r <= S_FIN;
              end else begin
                dstart_r <= 1'b1;
              end
            end else begin
              acc_r <= acc_r + 28'(drsp.dev);
              if (k_r == n_r - 9'd1) begin
                state_r <= S_FIN;
              end else begin
                dstart_r <= 1'b1;
              end
            end
            k_r <= k_r + 9'd1;
          end
        end
        S_SWR: begin
          state_r <= S_SWW;
        end
        S_SWW: begin
          if (!swp_r) begin
            hx_r <= rd_x;
            hy_r <= rd_y;
            swp_r <= 1'b1;
            state_r <= S_SWR;
          end else begin
            swp_r <= 1'b0;
            slo_r <= slo_r + 8'd1;
            shi_r <= shi_r - 8'd1;
            state_r <= (slo_r + 8'd1 < shi_r - 8'd1) ? S_SWR : S_FIN;
          end
        end
        S_FIN: begin
          if (op_r == ate_pkg::OpPropose && pch_r == '0 && k_r == 9'd8)
            pch_r <= acc_r[ate_pkg::DeltaW-1:0];
          if (op_r == ate_pkg::OpRecompute && n_r >= 9'd2)
            energy_r <= r_sat;
          if (!ovalid_r || out_tready) begin
            state_r <= S_IDLE;
            ovalid_r <= 1'b1;
            odata_r <= {1'b0, energy_r, pch_r, phi_r, plo_r};
            if (op_r == ate_pkg::OpPropose && k_r == 9'd8)
              odata_r <= {1'b0, energy_r, acc_r[ate_pkg::DeltaW-1:0], phi_r, plo_r};
            if (op_r == ate_pkg::OpRecompute && n_r >= 9'd2)
              odata_r <= {1'b0, r_sat, pch_r, phi_r, plo_r};
            if (op_r == ate_pkg::OpCommit) begin
              plo_r <= '0; phi_r <= '0; pch_r <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ATE_ASSERT_IMP(a_no_in_when_out, out_tvalid, !in_tready)
  `ATE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ATE_ASSERT_IMP(a_swap_order, state_r == S_SWR, slo_r < shi_r)

endmodule

[bench/tb_angle_tour_two_opt_engine.sv]
// Self-checking testbench for angle_tour_two_opt_engine: loads, proposes, commits
// and recomputes over a closed tour, predicting each result with a CORDIC angle model.
// Depends on ate_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_angle_tour_two_opt_engine;

  typedef enum int {K_ITEM, K_CFG, K_PAUSE} step_kind_t;

  typedef struct {
    step_kind_t        kind;
    logic [1:0]        op;
    logic [7:0]        idx;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [7:0]        a;
    logic [7:0]        b;
    logic [8:0]        val;
  } tour_step_t;

  typedef struct {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] delta;
    logic [25:0] energy;
  } tour_result_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;

  tour_step_t   plan[$];
  tour_result_t awaited[$];
  tour_step_t   held;
  int           quiet = 0;
  int           accepted = 0;
  int           errors = 0;
  bit           calm;

  longint xs[ate_pkg::MaxCities];
  longint ys[ate_pkg::MaxCities];
  longint tour_energy = 0;
  int     move_lo = 0;
  int     move_hi = 0;
  longint move_change = 0;
  int     city_cnt = 0;

  angle_tour_two_opt_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  assign calm = (accepted >= 600) && (accepted < 800);

  function automatic longint atan_step(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return longint'(1) << (30 - i);
    endcase
  endfunction

  function automatic longint arc_q30(longint ux, longint uy);
    longint big, vx, vy, z, dx, dy;
    big = (ux > uy) ? ux : uy;
    while (big < (longint'(1) << 40)) begin
      big = big << 1;
      ux = ux << 1;
      uy = uy << 1;
    end
    vx = ux;
    vy = uy;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx += dx; vy -= dy; z += atan_step(i);
      end else begin
        vx -= dx; vy += dy; z -= atan_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sd1686629713) z = 64'sd1686629713;
    return z;
  endfunction

  function automatic longint turn_dev(int c, int p, int q);
    longint v1x, v1y, v2x, v2y, u, cr, a;
    v1x = xs[p] - xs[c]; v1y = ys[p] - ys[c];
    v2x = xs[q] - xs[c]; v2y = ys[q] - ys[c];
    if ((v1x == 0 && v1y == 0) || (v2x == 0 && v2y == 0)) return 0;
    u = -(v1x * v2x + v1y * v2y);
    cr = v1x * v2y - v1y * v2x;
    a = arc_q30((u < 0) ? -u : u, (cr < 0) ? -cr : cr);
    if (u < 0) a = 64'sd3373259426 - a;
    return (a + (longint'(1) << 13)) >>> 14;
  endfunction

  function automatic int prv(int i, int n);
    return (i == 0) ? n - 1 : i - 1;
  endfunction

  function automatic int nxt(int i, int n);
    return (i == n - 1) ? 0 : i + 1;
  endfunction

  function automatic int used_cities();
    return (city_cnt > ate_pkg::MaxCities) ? ate_pkg::MaxCities : city_cnt;
  endfunction

  task automatic predict_propose(int a, int b);
    int n, lo, hi, pl, nl, ph, nh;
    longint old_sum, new_sum;
    n = used_cities();
    move_lo = 0; move_hi = 0; move_change = 0;
    if (n < 2 || a > n - 1 || b > n - 2) return;
    lo = a; hi = b;
    if (hi >= lo) hi++;
    else begin
      lo = b; hi = a;
    end
    move_lo = lo; move_hi = hi;
    if ((lo == 0 && hi == n - 1) || ((hi + 2) % n == lo)) return;
    pl = prv(lo, n); nl = nxt(lo, n);
    ph = prv(hi, n); nh = nxt(hi, n);
    old_sum = turn_dev(pl, prv(pl, n), lo) + turn_dev(lo, pl, nl)
            + turn_dev(hi, ph, nh) + turn_dev(nh, hi, nxt(nh, n));
    new_sum = turn_dev(pl, prv(pl, n), hi) + turn_dev(hi, pl, ph)
            + turn_dev(lo, nl, nh) + turn_dev(nh, lo, nxt(nh, n));
    move_change = new_sum - old_sum;
  endtask

  task automatic predict_item(tour_step_t s);
    tour_result_t r;
    longint e, t;
    int lo, hi, n;
    case (s.op)
      ate_pkg::OpLoad: begin
        xs[s.idx] = longint'($signed(s.x));
        ys[s.idx] = longint'($signed(s.y));
      end
      ate_pkg::OpPropose: predict_propose(int'(s.a), int'(s.b));
      ate_pkg::OpCommit: begin
        e = tour_energy + move_change;
        if (e < 0) e = 0;
        if (e > 64'sd67108863) e = 64'sd67108863;
        tour_energy = e;
        lo = move_lo; hi = move_hi;
        while (lo < hi) begin
          t = xs[lo]; xs[lo] = xs[hi]; xs[hi] = t;
          t = ys[lo]; ys[lo] = ys[hi]; ys[hi] = t;
          lo++; hi--;
        end
      end
      default: begin
        n = used_cities();
        e = 0;
        if (n >= 2)
          for (int i = 0; i < n; i++) e += turn_dev(i, prv(i, n), nxt(i, n));
        tour_energy = (e > 64'sd67108863) ? 64'sd67108863 : e;
      end
    endcase
    r.lo = move_lo[7:0];
    r.hi = move_hi[7:0];
    r.delta = move_change[20:0];
    r.energy = tour_energy[25:0];
    awaited.push_back(r);
    if (s.op == ate_pkg::OpCommit) begin
      move_lo = 0; move_hi = 0; move_change = 0;
    end
  endtask

  always @(posedge clk) begin
    bit took_item, took_cfg, nv, ncv;
    tour_step_t cmd;
    if (!rst_n) begin
      in_tvalid <= 0;
      cfg_valid <= 0;
    end else begin
      took_item = in_tvalid && in_tready;
      took_cfg = cfg_valid && cfg_ready;
      if (took_item) begin
        predict_item(held);
        accepted++;
      end
      if (took_cfg) city_cnt = int'(cfg_data);
      nv = in_tvalid && !took_item;
      ncv = cfg_valid && !took_cfg;
      if (!nv && !ncv && plan.size() > 0) begin
        cmd = plan[0];
        if (cmd.kind == K_ITEM) begin
          quiet = 0;
          if (calm || $urandom_range(99) >= 30) begin
            nv = 1;
            in_tdata <= {6'd0, cmd.b, cmd.a, cmd.y, cmd.x, cmd.idx, cmd.op};
            held = cmd;
            void'(plan.pop_front());
          end
        end else begin
          if (awaited.size() == 0 && !took_item && !took_cfg) quiet++;
          else quiet = 0;
          if (quiet >= 16) begin
            quiet = 0;
            if (cmd.kind == K_CFG) begin
              ncv = 1;
              cfg_data <= cmd.val;
            end
            void'(plan.pop_front());
          end
        end
      end
      in_tvalid <= nv;
      cfg_valid <= ncv;
    end
  end

  always @(posedge clk) begin
    tour_result_t want;
    logic [7:0]  got_lo, got_hi;
    logic [20:0] got_delta;
    logic [25:0] got_energy;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_lo = out_tdata[7:0];
        got_hi = out_tdata[15:8];
        got_delta = out_tdata[36:16];
        got_energy = out_tdata[62:37];
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item: %h", out_tdata);
        end else begin
          want = awaited.pop_front();
          if (got_lo !== want.lo || got_hi !== want.hi || got_delta !== want.delta ||
              got_energy !== want.energy) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %0d %0d %h %0d, got %0d %0d %h %0d",
                       want.lo, want.hi, want.delta, want.energy,
                       got_lo, got_hi, got_delta, got_energy);
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 30);
    end
  end

  task automatic add_item(logic [1:0] op, int idx, int x, int y, int a, int b);
    tour_step_t s;
    s.kind = K_ITEM; s.op = op; s.idx = 8'(idx); s.x = 16'(x); s.y = 16'(y);
    s.a = 8'(a); s.b = 8'(b); s.val = '0;
    plan.push_back(s);
  endtask

  task automatic add_cfg(int v);
    tour_step_t s;
    s.kind = K_CFG; s.op = ate_pkg::OpLoad; s.idx = '0; s.x = '0; s.y = '0;
    s.a = '0; s.b = '0; s.val = 9'(v);
    plan.push_back(s);
  endtask

  task automatic add_pause();
    tour_step_t s;
    s.kind = K_PAUSE; s.op = ate_pkg::OpLoad; s.idx = '0; s.x = '0; s.y = '0;
    s.a = '0; s.b = '0; s.val = '0;
    plan.push_back(s);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(9) < 3) return int'($urandom_range(2)) * 256;
    return int'($urandom() & 32'hFFFF);
  endfunction

  task automatic add_propose(int n);
    int m;
    m = (n > ate_pkg::MaxCities) ? ate_pkg::MaxCities : n;
    if (m >= 2 && $urandom_range(9) != 0)
      add_item(ate_pkg::OpPropose, $urandom(), $urandom(), $urandom(),
               $urandom_range(m - 1), $urandom_range(m - 2));
    else
      add_item(ate_pkg::OpPropose, $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom());
  endtask

  initial begin
    int sizes[15] = '{3, 4, 5, 6, 8, 12, 16, 32, 64, 256, 300, 511, 0, 1, 2};
    int made, n, len, r;
    bit paused;
    add_cfg(0);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpRecompute, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpCommit, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpLoad, 0, 'h7FFF, 'h8000, 0, 0);
    add_item(ate_pkg::OpLoad, 1, 'h8000, 'h7FFF, 0, 0);
    add_item(ate_pkg::OpLoad, 2, 'h8000, 'h7FFF, 0, 0);
    for (int i = 3; i < ate_pkg::MaxCities; i++)
      add_item(ate_pkg::OpLoad, i, rand_coord(), rand_coord(), 0, 0);
    add_cfg(1);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpRecompute, 0, 0, 0, 0, 0);
    add_cfg(2);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpRecompute, 0, 0, 0, 0, 0);
    add_cfg(5);
    add_item(ate_pkg::OpRecompute, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 0, 3);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 1, 3);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 5, 0);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 0, 4);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 2, 0);
    add_item(ate_pkg::OpCommit, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpCommit, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 1, 1);
    add_item(ate_pkg::OpCommit, 0, 0, 0, 0, 0);
    add_cfg(256);
    add_item(ate_pkg::OpPropose, 0, 0, 0, 255, 254);
    add_item(ate_pkg::OpCommit, 0, 0, 0, 0, 0);
    add_item(ate_pkg::OpRecompute, 0, 0, 0, 0, 0);
    add_cfg(511);
    add_item(ate_pkg::OpRecompute, 0, 0, 0, 0, 0);

    made = 0;
    paused = 0;
    while (made < 1000) begin
      n = sizes[$urandom_range(14)];
      add_cfg(n);
      len = $urandom_range(20, 80);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 55) begin
          add_propose(n);
          made++;
          if ($urandom_range(9) < 6) begin
            add_item(ate_pkg::OpCommit, $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom());
            made++;
          end
        end else if (r < 65) begin
          add_item(ate_pkg::OpCommit, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom());
          made++;
        end else if (r < 88) begin
          add_item(ate_pkg::OpLoad, $urandom(), rand_coord(), rand_coord(), $urandom(),
                   $urandom());
          made++;
        end else if (n <= 64 || $urandom_range(19) == 0) begin
          add_item(ate_pkg::OpRecompute, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom());
          made++;
        end
        if (!paused && made > 400) begin
          paused = 1;
          add_pause();
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (plan.size() > 0 || in_tvalid || cfg_valid || awaited.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && awaited.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
